/* hdl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk outside reset (rst_n low).
`define PHX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define PHX_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/phx_pkg.sv */
// Philox-4x32 generator package: payload types and round constants.
package phx_pkg;

  localparam logic [31:0] MUL_A   = 32'hD2511F53;
  localparam logic [31:0] MUL_B   = 32'hCD9E8D57;
  localparam logic [31:0] WEYL_LO = 32'h9E3779B9;
  localparam logic [31:0] WEYL_HI = 32'hBB67AE85;

  typedef struct packed {
    logic [63:0] block_index;
    logic [63:0] counter_word;
  } in_item_t;

  typedef struct packed {
    logic [31:0] word0;
    logic [31:0] word1;
    logic [31:0] word2;
    logic [31:0] word3;
  } out_item_t;

  typedef struct packed {
    logic [31:0] x0;
    logic [31:0] x1;
    logic [31:0] x2;
    logic [31:0] x3;
  } phx_state_t;

endpackage

/* hdl/phx_round.sv */
// One registered Philox round: two 32x32 products, XOR mix with the round key.
module phx_round #(
  parameter int unsigned ROUND_IDX = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_valid,
  input  phx_pkg::phx_state_t in_state,
  input  logic [63:0]         key,
  output logic                valid_r,
  output phx_pkg::phx_state_t state_r
);

  // round key offset: ROUND_IDX raises, modulo 2^32
  localparam logic [63:0] LO_OFF64 = 64'(ROUND_IDX) * 64'(phx_pkg::WEYL_LO);
  localparam logic [63:0] HI_OFF64 = 64'(ROUND_IDX) * 64'(phx_pkg::WEYL_HI);
  localparam logic [31:0] K0_OFF   = LO_OFF64[31:0];
  localparam logic [31:0] K1_OFF   = HI_OFF64[31:0];

  logic [31:0]         k0;
  logic [31:0]         k1;
  logic [63:0]         p0;
  logic [63:0]         p1;
  phx_pkg::phx_state_t state_nxt;
  logic                valid_nxt;

  assign k0 = key[31:0] + K0_OFF;
  assign k1 = key[63:32] + K1_OFF;
  assign p0 = 64'(phx_pkg::MUL_A) * 64'(in_state.x0);
  assign p1 = 64'(phx_pkg::MUL_B) * 64'(in_state.x2);

  always_comb begin
    state_nxt.x0 = p1[63:32] ^ in_state.x1 ^ k0;
    state_nxt.x1 = p1[31:0];
    state_nxt.x2 = p0[63:32] ^ in_state.x3 ^ k1;
    state_nxt.x3 = p0[31:0];
    valid_nxt    = in_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hdl/philox_4x32_10_generator_unit.sv */
// Philox-4x32 generator top level: key register and a round-per-stage pipeline.
//
// Input channel in_valid/in_stall/in_data carries a 64-bit block index and a
// 64-bit counter; output channel out_valid/out_stall/out_data returns the four
// 32-bit words of the Philox block. A transaction moves on a rising edge with
// valid high and stall low.
// The 64-bit key is written through cfg_valid/cfg_ready/cfg_key; cfg_ready is
// always high. Write it only while no transaction is in flight.
// An input transaction passes through the round stages in order to out_valid.
// Throughput: one transaction per cycle while out_stall is low. Each pipeline
// stage is one round with two 32x32 multipliers; the stage count sets the latency.
// When out_stall is high, held results stay in place and bubbles in the
// pipeline still close up; in_stall rises only when every stage is full and
// the output is stalled.
// Synchronous reset (rst_n low) empties the pipeline and clears the key to 0.
module philox_4x32_10_generator_unit #(
  parameter int unsigned ROUNDS = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  phx_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output phx_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [63:0]        cfg_key
);

  logic [63:0]         key_r;
  logic [ROUNDS:0]     rdy;
  logic [ROUNDS-1:0]   vld;
  phx_pkg::phx_state_t st [ROUNDS];
  phx_pkg::phx_state_t st_in;
  phx_pkg::phx_state_t st_last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      key_r <= cfg_key;
    end
  end

  always_comb begin
    st_in.x0 = in_data.block_index[31:0];
    st_in.x1 = in_data.block_index[63:32];
    st_in.x2 = in_data.counter_word[31:0];
    st_in.x3 = in_data.counter_word[63:32];
  end

  // a stage loads when it is empty or its content moves on
  assign rdy[ROUNDS] = !out_stall;

  genvar g;
  generate
    for (g = 0; g < ROUNDS; g++) begin : g_round
      assign rdy[g] = !vld[g] || rdy[g+1];

      if (g == 0) begin : g_first
        phx_round #(.ROUND_IDX(g)) u_round (
          .clk      (clk),
          .rst_n    (rst_n),
          .adv      (rdy[g]),
          .in_valid (in_valid),
          .in_state (st_in),
          .key      (key_r),
          .valid_r  (vld[g]),
          .state_r  (st[g])
        );
      end else begin : g_next
        phx_round #(.ROUND_IDX(g)) u_round (
          .clk      (clk),
          .rst_n    (rst_n),
          .adv      (rdy[g]),
          .in_valid (vld[g-1]),
          .in_state (st[g-1]),
          .key      (key_r),
          .valid_r  (vld[g]),
          .state_r  (st[g])
        );
      end
    end
  endgenerate

  assign in_stall  = !rdy[0];
  assign out_valid = vld[ROUNDS-1];
  assign st_last   = st[ROUNDS-1];

  always_comb begin
    out_data.word0 = st_last.x0;
    out_data.word1 = st_last.x1;
    out_data.word2 = st_last.x2;
    out_data.word3 = st_last.x3;
  end

endmodule

/* hdl/phx_checker.sv */
// Port-level checker for the Philox generator, bound to the top level.
`include "assert_macros.svh"

module phx_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input phx_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input phx_pkg::out_item_t out_data,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [63:0]        cfg_key
);

  logic unused_ok;
  logic out_held;
  assign unused_ok = in_valid ^ (^in_data) ^ (^cfg_key);
  assign out_held  = out_valid && out_stall;

  `PHX_ASSERT(a_out_hold, out_held |=> out_valid && $stable(out_data), "held result changed")
  `PHX_ASSERT(a_stall_only_full, in_stall |-> out_held, "input stalled while output free")
  `PHX_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid && !in_stall, "not empty after reset")
  `PHX_ASSERT(a_cfg_ready, cfg_valid |-> cfg_ready, "key write not taken")

endmodule

bind philox_4x32_10_generator_unit phx_checker u_phx_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_key   (cfg_key)
);

/* tb/sv/tb_top.sv */
// Self-checking testbench for the Philox-4x32 generator: keyed phases, burst traffic, stalls.
module tb_top;

  localparam int unsigned ROUNDS = 10;
  localparam int ITEMS_PER_KEY = 92;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  phx_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  phx_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [63:0] cfg_key = '0;

  phx_pkg::in_item_t pending_blocks[$];
  phx_pkg::out_item_t expected_words[$];
  logic [63:0] model_key = '0;
  int error_count = 0;
  int cycle_count = 0;

  int burst_left = 0;
  int gap_left = 0;

  int results_seen = 0;
  int hold_left = 0;
  int next_hold_at = 150;
  int stall_mode = 0;
  int mode_left = 0;

  philox_4x32_10_generator_unit #(.ROUNDS(ROUNDS)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_key(cfg_key)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic phx_pkg::out_item_t philox_words(input phx_pkg::in_item_t item,
                                                      input logic [63:0] key);
    logic [31:0] k0;
    logic [31:0] k1;
    logic [63:0] prod_a;
    logic [63:0] prod_b;
    phx_pkg::phx_state_t st;
    phx_pkg::phx_state_t nxt;
    phx_pkg::out_item_t res;
    int r;
    k0 = key[31:0];
    k1 = key[63:32];
    st.x0 = item.block_index[31:0];
    st.x1 = item.block_index[63:32];
    st.x2 = item.counter_word[31:0];
    st.x3 = item.counter_word[63:32];
    for (r = 0; r < ROUNDS; r++) begin
      prod_a = {32'h0, phx_pkg::MUL_A} * {32'h0, st.x0};
      prod_b = {32'h0, phx_pkg::MUL_B} * {32'h0, st.x2};
      nxt.x0 = prod_b[63:32] ^ st.x1 ^ k0;
      nxt.x1 = prod_b[31:0];
      nxt.x2 = prod_a[63:32] ^ st.x3 ^ k1;
      nxt.x3 = prod_a[31:0];
      st = nxt;
      if (r + 1 < ROUNDS) begin
        k0 = k0 + phx_pkg::WEYL_LO;
        k1 = k1 + phx_pkg::WEYL_HI;
      end
    end
    res.word0 = st.x0;
    res.word1 = st.x1;
    res.word2 = st.x2;
    res.word3 = st.x3;
    return res;
  endfunction

  function automatic logic [31:0] pick_half();
    case ($urandom_range(0, 15))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_block(input logic [63:0] index_val, input logic [63:0] count_val);
    phx_pkg::in_item_t item;
    item.block_index = index_val;
    item.counter_word = count_val;
    pending_blocks.push_back(item);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_blocks.size() != 0 || expected_words.size() != 0 || in_valid);
  endtask

  task automatic load_key(input logic [63:0] key_val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_key <= key_val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    model_key = key_val;
  endtask

  // driver: bursts of transactions with random gaps, payload held while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_words.push_back(philox_words(in_data, model_key));
        void'(pending_blocks.pop_front());
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_blocks.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= pending_blocks[0];
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, with long hold-offs to back the pipeline up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (results_seen >= next_hold_at) begin
        hold_left = LONG_HOLD;
        next_hold_at += 250;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 64);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (mode_left % 3 == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : monitor
    phx_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("unexpected result transaction %h", out_data);
        error_count++;
      end else begin
        want = expected_words.pop_front();
        if (out_data.word0 !== want.word0) begin
          $error("word0: expected %h, got %h", want.word0, out_data.word0);
          error_count++;
        end
        if (out_data.word1 !== want.word1) begin
          $error("word1: expected %h, got %h", want.word1, out_data.word1);
          error_count++;
        end
        if (out_data.word2 !== want.word2) begin
          $error("word2: expected %h, got %h", want.word2, out_data.word2);
          error_count++;
        end
        if (out_data.word3 !== want.word3) begin
          $error("word3: expected %h, got %h", want.word3, out_data.word3);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    logic [63:0] key_plan[6];
    int p;
    int n;
    key_plan[0] = 64'hFFFF_FFFF_FFFF_FFFF;
    key_plan[1] = {$urandom, $urandom};
    key_plan[2] = 64'h0000_0000_FFFF_FFFF;
    key_plan[3] = 64'hFFFF_FFFF_0000_0000;
    key_plan[4] = {$urandom, $urandom};
    key_plan[5] = 64'h0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset key of zero, corner patterns
    queue_block(64'h0, 64'h0);
    queue_block(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_block(64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_block(64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
    queue_block(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    queue_block(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    queue_block(64'h1, 64'h0);
    queue_block(64'h0, 64'h1);
    queue_block(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
    queue_block(64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000);
    queue_block(64'h0000_0001_0000_0000, 64'h0000_0000_8000_0000);
    queue_block(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
    wait_drained();

    for (p = 0; p < 6; p++) begin
      load_key(key_plan[p]);
      queue_block(64'h0, 64'h0);
      queue_block(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      for (n = 0; n < ITEMS_PER_KEY - 2; n++) begin
        queue_block({pick_half(), pick_half()}, {pick_half(), pick_half()});
      end
      wait_drained();
    end

    repeat (ROUNDS + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
